// ===== design/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants for the integer to ASCII converter
// Word structs, conversion kind codes, character constants, digit sizing.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int VALUE_W       = 32;

	// conversion kinds
	localparam logic [1:0] FUNC_SDEC    = 2'd0;
	localparam logic [1:0] FUNC_UDEC    = 2'd1;
	localparam logic [1:0] FUNC_HEX     = 2'd2;
	localparam logic [1:0] FUNC_HEX_ALT = 2'd3;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h41;

	typedef struct packed {
		logic [1:0]         func;
		logic [VALUE_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} out_word_t;

	// shift/adjust unit status
	typedef struct packed {
		logic busy;
		logic done;
	} dab_stat_t;

	// emitter load command
	typedef struct packed {
		logic load;
		logic neg;
	} emit_cmd_t;

	// decimal digits needed for a wb-bit unsigned word (77/256 ~ log10(2))
	function automatic int dec_digits(input int wb);
		return (wb * 77) / 256 + 1;
	endfunction

	// digit slots: enough for decimal and for hex
	function automatic int num_digits(input int wb);
		int d;
		int h;
		d = dec_digits(wb);
		h = (wb + 3) / 4;
		return (d > h) ? d : h;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CHAR_ZERO + {4'd0, nib};
		end else begin
			r = CHAR_A + {4'd0, nib - 4'd10};
		end
		return r;
	endfunction

endpackage

// ===== design/i2a_dabble.sv =====
// ----------------------------------------------------------------------------
// i2a_dabble: binary to BCD shift/adjust unit
// One bit per cycle; every digit gets add-3 when >= 5, then the chain shifts.
// ----------------------------------------------------------------------------
module i2a_dabble #(
	parameter int WORD_BITS = i2a_pkg::WORD_BITS_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               start,
	input  logic [WORD_BITS-1:0]                               bin,
	output logic [4*i2a_pkg::num_digits(WORD_BITS)-1:0]        bcd,
	output i2a_pkg::dab_stat_t                                 stat
);
	import i2a_pkg::*;

	localparam int NUM_DIGITS = num_digits(WORD_BITS);
	localparam int DIG_W      = 4 * NUM_DIGITS;
	localparam int CNT_W      = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] bin_q;
	logic [DIG_W-1:0]     bcd_q;
	logic [DIG_W-1:0]     adj;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// one-cycle pulse right after the final shift
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[WORD_BITS-2:0], 1'b0};
			bcd_q <= {adj[DIG_W-2:0], bin_q[WORD_BITS-1]};
		end
	end

	assign bcd       = bcd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== design/i2a_emit.sv =====
// ----------------------------------------------------------------------------
// i2a_emit: character sequencer and output register
// Walks the digit slots from the top, skips leading zeros, sends characters.
// ----------------------------------------------------------------------------
module i2a_emit #(
	parameter int WORD_BITS = i2a_pkg::WORD_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  i2a_pkg::emit_cmd_t                          cmd,
	input  logic [4*i2a_pkg::num_digits(WORD_BITS)-1:0] digits,
	output logic                                        busy,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output i2a_pkg::out_word_t                          out_word
);
	import i2a_pkg::*;

	localparam int NUM_DIGITS = num_digits(WORD_BITS);
	localparam int DIG_W      = 4 * NUM_DIGITS;
	localparam int REM_W      = $clog2(NUM_DIGITS + 1);

	logic [DIG_W-1:0] dig_q;
	logic [REM_W-1:0] rem_q;
	logic             neg_q;
	logic             started_q;
	logic             active_q;
	logic             out_valid_q;
	out_word_t        out_q;

	logic [3:0] top_dig;
	logic       slot_free;
	logic       do_sign;
	logic       do_skip;
	logic       do_digit;

	assign top_dig   = dig_q[DIG_W-1 -: 4];
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		do_sign  = 1'b0;
		do_skip  = 1'b0;
		do_digit = 1'b0;
		if (active_q) begin
			if (neg_q) begin
				do_sign = slot_free;
			end else if (!started_q && (top_dig == 4'd0) && (rem_q > REM_W'(1))) begin
				do_skip = 1'b1;
			end else begin
				do_digit = slot_free;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			neg_q       <= 1'b0;
			started_q   <= 1'b0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// hold a stalled word, else take a new character if one is made
			out_valid_q <= (out_valid_q && !out_ready) ||
				(!cmd.load && (do_sign || do_digit));
			if (cmd.load) begin
				rem_q     <= REM_W'(NUM_DIGITS);
				neg_q     <= cmd.neg;
				started_q <= 1'b0;
				active_q  <= 1'b1;
			end else begin
				if (do_sign) begin
					neg_q <= 1'b0;
				end
				if (do_skip || do_digit) begin
					rem_q <= rem_q - REM_W'(1);
				end
				if (do_digit) begin
					started_q <= 1'b1;
					if (rem_q == REM_W'(1)) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dig_q <= digits;
		end else if (do_skip || do_digit) begin
			dig_q <= {dig_q[DIG_W-5:0], 4'd0};
		end
		if (do_sign) begin
			out_q.char_code <= CHAR_MINUS;
			out_q.last      <= 1'b0;
		end else if (do_digit) begin
			out_q.char_code <= hex_char(top_dig);
			out_q.last      <= (rem_q == REM_W'(1));
		end
	end

	assign busy      = active_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

// ===== design/integer_to_ascii_converter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_converter_unit: binary word to ASCII text
// Signed decimal, unsigned decimal or upper-case hex, one character per word.
// ----------------------------------------------------------------------------
// Each accepted input word carries a value and a conversion kind; the unit
// sends its text, most significant character first, one output word per
// character, with last set on the final one. Signed decimal puts '-' before
// the magnitude of a negative value (the most negative value prints its
// unsigned magnitude); zero prints a single '0'; kind code three acts as hex.
// Only the low WORD_BITS bits of value are used. The unit takes one number at
// a time: in_ready is low from acceptance until the control state returns to
// idle, after the last character has entered the output register and the
// emitter has gone idle. A decimal number goes through the one-bit-per-cycle
// shift/add-3 unit, then loads the emitter, which walks the digit slots
// (num_digits(WORD_BITS), 10 at 32 bits) for leading-zero skip and output,
// after sending the sign of a negative value. Hex skips the shift unit and
// loads the emitter on acceptance. A character that waits on a full, stalled
// output register holds the emitter until the register drains.
module integer_to_ascii_converter_unit #(
	parameter int WORD_BITS = i2a_pkg::WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  i2a_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output i2a_pkg::out_word_t out_word
);
	import i2a_pkg::*;

	localparam int NUM_DIGITS = num_digits(WORD_BITS);
	localparam int DIG_W      = 4 * NUM_DIGITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   neg_q;

	logic                 accept;
	logic                 is_hex;
	logic                 is_neg;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] mag;
	logic [DIG_W-1:0]     bcd;
	logic [DIG_W-1:0]     digits;
	logic                 emit_busy;
	dab_stat_t            dab_stat;
	emit_cmd_t            emit_cmd;

	// mask or zero-extend the value to the working width
	generate
		if (WORD_BITS <= VALUE_W) begin : g_trunc
			assign word = in_word.value[WORD_BITS-1:0];
		end else begin : g_ext
			assign word = WORD_BITS'(in_word.value);
		end
	endgenerate

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_hex   = (in_word.func == FUNC_HEX) || (in_word.func == FUNC_HEX_ALT);
	assign is_neg   = (in_word.func == FUNC_SDEC) && word[WORD_BITS-1];
	// two's complement magnitude; most negative value stays as its unsigned bits
	assign mag      = is_neg ? (~word + WORD_BITS'(1)) : word;

	// hex goes straight to the emitter, nibbles already are digits
	always_comb begin
		emit_cmd.load = 1'b0;
		emit_cmd.neg  = 1'b0;
		digits        = bcd;
		if (state_q == ST_IDLE) begin
			emit_cmd.load = accept && is_hex;
			digits        = DIG_W'(mag);
		end else if (state_q == ST_CONV) begin
			emit_cmd.load = dab_stat.done;
			emit_cmd.neg  = neg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= is_neg;
						state_q <= is_hex ? ST_EMIT : ST_CONV;
					end
				end
				ST_CONV: begin
					if (dab_stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// emitter goes busy the cycle after load
					if (!emit_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	i2a_dabble #(
		.WORD_BITS(WORD_BITS)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && !is_hex),
		.bin    (mag),
		.bcd    (bcd),
		.stat   (dab_stat)
	);

	i2a_emit #(
		.WORD_BITS(WORD_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (emit_cmd),
		.digits    (digits),
		.busy      (emit_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

// ===== design/i2a_checker.sv =====
// ----------------------------------------------------------------------------
// i2a_checker: port-level checks for the integer to ASCII converter
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module i2a_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input i2a_pkg::in_word_t  in_word,
	input logic               out_valid,
	input logic               out_ready,
	input i2a_pkg::out_word_t out_word
);
	import i2a_pkg::*;

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// one number at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a number is in progress");

	// ready again only once the run's final character is queued
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_word.last)
		else $error("ready while characters of a run remain");

	// a sign is never the end of a run
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.char_code == CHAR_MINUS) |-> !out_word.last)
		else $error("minus sign marked last");

endmodule

bind integer_to_ascii_converter_unit i2a_checker u_i2a_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: integer to ASCII converter unit
// Sends numbers in every conversion kind. Each accepted number is turned into
// its expected text, either typed into the directed table or worked out by a
// local formatter. Every character that leaves the unit is compared against
// that text, in order, with random idling on both sides and then with none.
// ----------------------------------------------------------------------------
module testbench;
	import i2a_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE0_RANDOM = 100;
	localparam int PHASE1_RANDOM = 120;
	localparam int PHASE2_RANDOM = 136;

	// one row of the directed table; empty text means the formatter decides
	typedef struct {
		logic [1:0]  func;
		logic [31:0] value;
		string       text;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 24;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{FUNC_SDEC,    32'h0000_0000, "0"},
		'{FUNC_UDEC,    32'h0000_0000, "0"},
		'{FUNC_HEX,     32'h0000_0000, "0"},
		'{FUNC_HEX_ALT, 32'h0000_0000, "0"},
		'{FUNC_SDEC,    32'h8000_0000, "-2147483648"},  // most negative word
		'{FUNC_UDEC,    32'h8000_0000, "2147483648"},
		'{FUNC_SDEC,    32'h7FFF_FFFF, "2147483647"},
		'{FUNC_SDEC,    32'hFFFF_FFFF, "-1"},
		'{FUNC_UDEC,    32'hFFFF_FFFF, "4294967295"},
		'{FUNC_HEX,     32'hFFFF_FFFF, "FFFFFFFF"},
		'{FUNC_HEX_ALT, 32'hFFFF_FFFF, "FFFFFFFF"},
		'{FUNC_HEX,     32'h8000_0000, "80000000"},
		'{FUNC_SDEC,    32'h0000_0001, "1"},
		'{FUNC_UDEC,    32'h0000_0009, "9"},
		'{FUNC_UDEC,    32'h0000_000A, "10"},
		'{FUNC_HEX,     32'h0000_000A, "A"},
		'{FUNC_HEX,     32'h89AB_CDEF, "89ABCDEF"},
		'{FUNC_UDEC,    32'd1000000000, "1000000000"},
		'{FUNC_SDEC,    32'hC465_3600, "-1000000000"},
		'{FUNC_SDEC,    32'hFFFF_FFF6, "-10"},
		'{FUNC_HEX,     32'h0123_4567, ""},
		'{FUNC_SDEC,    32'h5A5A_5A5A, ""},
		'{FUNC_UDEC,    32'hA5A5_A5A5, ""},
		'{FUNC_HEX_ALT, 32'h1234_ABCD, ""}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	// characters still owed by the unit, oldest first
	out_word_t expected_chars [$];
	int        mismatch_count = 0;
	int        cycle_count = 0;
	// idle odds in percent for the sender and the receiver
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;

	integer_to_ascii_converter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always #(CLK_HALF) clk = ~clk;

	// Formatter: text of one number, most significant character first.
	// Signed kind negates a word with its top bit set; the most negative word
	// comes out of the negation unchanged, which is its unsigned magnitude.
	// Func bit 1 picks base sixteen, so kind three is plain hex.
	function automatic string format_number(input logic [1:0] kind, input logic [31:0] raw);
		string       digit_set;
		string       txt;
		logic [31:0] mag;
		logic        neg;
		int unsigned base;
		int          d;
		digit_set = "0123456789ABCDEF";
		txt = "";
		neg = (kind == FUNC_SDEC) && raw[31];
		mag = neg ? (~raw + 32'd1) : raw;
		base = kind[1] ? 16 : 10;
		// zero still yields one digit
		do begin
			d = int'(mag % base);
			txt = {digit_set.substr(d, d), txt};
			mag = mag / base;
		end while (mag != 32'd0);
		if (neg) begin
			txt = {"-", txt};
		end
		return txt;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// one expected word per character, last set on the final one
	task automatic queue_text(input string txt);
		out_word_t w;
		for (int i = 0; i < txt.len(); i++) begin
			w.char_code = txt[i];
			w.last = (i == txt.len() - 1);
			expected_chars.push_back(w);
		end
	endtask

	// Called just after a rising edge. Idles at random, then holds the word
	// until the unit takes it and queues what it should print.
	task automatic send_number(input logic [1:0] f, input logic [31:0] v, input string txt);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= '{func: f, value: v};
		do @(posedge clk); while (!in_ready);
		queue_text((txt != "") ? txt : format_number(f, v));
	endtask

	// random number shaped to reach every digit count and the sign boundary
	task automatic send_random_number();
		logic [31:0] v;
		logic [31:0] p;
		case ($urandom_range(6))
			0: v = $urandom();
			1: v = $urandom_range(20);
			2: v = $urandom() >> $urandom_range(31);
			3: v = 32'd0 - $urandom_range(1000);
			4: v = 32'hFFFF_FFFF - $urandom_range(15);
			5: v = 32'h7FFF_FFF8 + $urandom_range(15);
			default: begin
				// around a power of ten
				p = 32'd1;
				repeat ($urandom_range(9)) p = p * 32'd10;
				v = p + $urandom_range(2) - 32'd1;
			end
		endcase
		send_number(2'($urandom_range(3)), v, "");
	endtask

	// receiver side: random back pressure at the current odds
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// output checker: every taken character against the oldest one owed
	always @(posedge clk) begin : check_chars
		out_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char %02h last %0b",
					out_word.char_code, out_word.last));
			end else begin
				exp_w = expected_chars.pop_front();
				if (out_word.char_code !== exp_w.char_code) begin
					report_mismatch($sformatf("char_code %02h, expected %02h",
						out_word.char_code, exp_w.char_code));
				end
				if (out_word.last !== exp_w.last) begin
					report_mismatch($sformatf("last %0b on char %02h, expected %0b",
						out_word.last, exp_w.char_code, exp_w.last));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[integer_to_ascii_converter_unit] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int drain;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender lazy, receiver slow: directed table first
		tx_idle_pct = 26;
		rx_idle_pct <= 72;
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_number(directed_rows[i].func, directed_rows[i].value, directed_rows[i].text);
		end
		repeat (PHASE0_RANDOM) send_random_number();

		// sender slow, receiver mostly ready
		tx_idle_pct = 72;
		rx_idle_pct <= 26;
		repeat (PHASE1_RANDOM) send_random_number();

		// back to back, no stalls
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		repeat (PHASE2_RANDOM) send_random_number();
		in_valid <= 1'b0;

		// drain, then give stray characters a chance to show up
		while (expected_chars.size() != 0) @(posedge clk);
		for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clk);

		if (expected_chars.size() != 0) begin
			report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
		end
		if (mismatch_count == 0) begin
			$display("[integer_to_ascii_converter_unit] OK");
		end else begin
			$display("[integer_to_ascii_converter_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== integer_to_ascii_converter_unit.f =====
design/i2a_pkg.sv
design/i2a_dabble.sv
design/i2a_emit.sv
design/integer_to_ascii_converter_unit.sv
design/i2a_checker.sv
sim/testbench.sv
